// ----- rtl/ps2md_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse decoder package
// Event codes, register indexes, slot layout and the motion saturation helper.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  typedef enum logic [1:0] {
    EV_PRESSED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_SCROLLED = 2'd2,
    EV_MOVED    = 2'd3
  } ev_kind_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIVE_BUTTONS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_SCALE  = 2'd2;

  // Pending event slots, drained lowest first: buttons 0..4, scroll, move
  localparam int unsigned NUM_BUTTONS = 5;
  localparam int unsigned SLOT_SCROLL = 5;
  localparam int unsigned SLOT_MOVE   = 6;
  localparam int unsigned NUM_SLOTS   = 7;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // Clamp an 18-bit signed sum into the 16-bit accumulator range
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ps2_mouse_packet_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Assembles mouse bytes into 3- or 4-byte packets and emits button, scroll and
// accumulated motion events.
// ----------------------------------------------------------------------------
// Each input transaction carries either one mouse byte or a flush request.
// Bytes are gathered into packets of three bytes, or four when wheel_present
// or five_buttons is set; a first byte without bit 3 set is dropped to regain
// sync. A finished packet produces a press or release event for each button
// whose level changed (buttons 0..2, then 3..4 in five-button mode) followed
// by a scroll event for a nonzero wheel value if wheel_present is set; its
// X and negated Y motion, doubled when bit 1 of motion_scale is set, go
// into saturating 16-bit accumulators. A flush emits one move event when
// either accumulator is nonzero and clears both. The last event caused by
// an input transaction has last_of_run set. Timing: an accepted transaction
// is decoded out of the input register into a pending-event register, which
// drains into the output register one event per cycle while the output is
// not stalled. A transaction yields at most six events. The next transaction
// is taken into the input register while the previous events are still
// draining, so bytes may arrive every cycle unless in_stall holds them.
// Configuration writes are always ready and are to be issued only while the
// block is idle.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder
  import ps2md_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,

  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [CFG_DAT_W-1:0] cfg_data,

  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_action,
  input  wire  [7:0]           in_data_byte,

  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [1:0]           out_event_kind,
  output logic [2:0]           out_button_index,
  output logic signed [7:0]    out_scroll_amount,
  output logic signed [15:0]   out_move_x,
  output logic signed [15:0]   out_move_y,
  output logic                 out_last_of_run
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       wheel_r;
  logic       five_r;
  logic [1:0] scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_r <= 1'b0;
      five_r  <= 1'b0;
      scale_r <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WHEEL_PRESENT: wheel_r <= cfg_data[0];
        CFG_FIVE_BUTTONS:  five_r  <= cfg_data[0];
        CFG_MOTION_SCALE:  scale_r <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  // input stage
  logic        in_vld_r, in_vld_nxt;
  logic        in_act_r;
  logic [7:0]  in_byte_r;

  // decoder state
  logic [1:0]                pos_r, pos_nxt;
  logic [7:0]                store_r [3];
  logic [NUM_BUTTONS-1:0]    levels_r, levels_nxt;
  logic signed [15:0]        pend_x_r, pend_x_nxt;
  logic signed [15:0]        pend_y_r, pend_y_nxt;

  // pending events of the current transaction
  slot_mask_t                mask_r, mask_nxt;
  logic [NUM_BUTTONS-1:0]    press_r;
  logic signed [7:0]         scroll_r;
  logic signed [15:0]        mvx_r;
  logic signed [15:0]        mvy_r;

  // output register
  logic                      out_vld_r, out_vld_nxt;
  ev_kind_t                  out_kind_r;
  logic [2:0]                out_btn_r;
  logic signed [7:0]         out_scroll_r;
  logic signed [15:0]        out_mx_r;
  logic signed [15:0]        out_my_r;
  logic                      out_last_r;

  // --------------------------------------------------------------------------
  // Drain: pick the lowest pending slot when the output register frees up
  // --------------------------------------------------------------------------
  logic       out_adv;
  logic       drain;
  logic [2:0] pick_idx;
  slot_mask_t pick_bit;
  slot_mask_t mask_after;
  logic       proc;

  always_comb begin
    pick_idx = '0;
    pick_bit = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick_idx = 3'(i);
        pick_bit = slot_mask_t'(1) << i;
      end
    end
  end

  assign out_adv    = !out_vld_r || !out_stall;
  assign drain      = out_adv && (mask_r != '0);
  assign mask_after = drain ? (mask_r & ~pick_bit) : mask_r;

  // Decode the held transaction once all earlier events have left the
  // pending register (or leave it this cycle).
  assign proc     = in_vld_r && (mask_after == '0);
  assign in_stall = in_vld_r && !proc;

  // --------------------------------------------------------------------------
  // Packet decode
  // --------------------------------------------------------------------------
  logic                   len4;
  logic                   drop;
  logic                   complete;
  logic                   store_we;
  logic [7:0]             b0, b1, b2, b3;
  logic [NUM_BUTTONS-1:0] lv;
  logic signed [8:0]      xm, ym;
  logic signed [9:0]      xs, yneg;
  logic signed [10:0]     ys;
  logic signed [17:0]     sum_x, sum_y;
  logic signed [7:0]      wheel;
  slot_mask_t             new_mask;

  always_comb begin
    len4     = wheel_r || five_r;
    drop     = (pos_r == 2'd0) && !in_byte_r[3];
    complete = !drop && ((pos_r == 2'd3) || ((pos_r == 2'd2) && !len4));
    store_we = proc && !in_act_r && !drop && (pos_r != 2'd3);

    b0 = store_r[0];
    b1 = store_r[1];
    b2 = (pos_r == 2'd2) ? in_byte_r : store_r[2];
    b3 = in_byte_r;

    // new button levels; buttons 3 and 4 keep their level outside five-button mode
    lv[2:0] = b0[2:0];
    lv[4:3] = five_r ? b3[5:4] : levels_r[4:3];

    // nine-bit two's complement motion, sign bits in byte 0
    xm   = {b0[4], b1};
    ym   = {b0[5], b2};
    xs   = scale_r[1] ? {xm, 1'b0} : {xm[8], xm};
    yneg = -{ym[8], ym};
    ys   = scale_r[1] ? {yneg, 1'b0} : {yneg[9], yneg};
    sum_x = {{2{pend_x_r[15]}}, pend_x_r} + {{8{xs[9]}}, xs};
    sum_y = {{2{pend_y_r[15]}}, pend_y_r} + {{7{ys[10]}}, ys};

    wheel = five_r ? {{4{b3[3]}}, b3[3:0]} : b3;

    new_mask   = '0;
    levels_nxt = levels_r;
    pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;
    pos_nxt    = pos_r;

    if (proc) begin
      if (in_act_r) begin
        // flush: one move event, then clear the accumulators
        new_mask[SLOT_MOVE] = (pend_x_r != '0) || (pend_y_r != '0);
        pend_x_nxt = '0;
        pend_y_nxt = '0;
      end else if (complete) begin
        new_mask[NUM_BUTTONS-1:0] = lv ^ levels_r;
        new_mask[SLOT_SCROLL]     = wheel_r && (wheel != '0);
        levels_nxt = lv;
        pend_x_nxt = sat16(sum_x);
        pend_y_nxt = sat16(sum_y);
        pos_nxt    = 2'd0;
      end else if (!drop) begin
        pos_nxt = pos_r + 2'd1;
      end
    end

    mask_nxt    = proc ? new_mask : mask_after;
    in_vld_nxt  = (in_valid && !in_stall) ? 1'b1 : (proc ? 1'b0 : in_vld_r);
    out_vld_nxt = drain ? 1'b1 : (out_adv ? 1'b0 : out_vld_r);
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mask_r    <= '0;
      pos_r     <= 2'd0;
      levels_r  <= '0;
      pend_x_r  <= '0;
      pend_y_r  <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      mask_r    <= mask_nxt;
      pos_r     <= pos_nxt;
      levels_r  <= levels_nxt;
      pend_x_r  <= pend_x_nxt;
      pend_y_r  <= pend_y_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // capture the transaction
    if (in_valid && !in_stall) begin
      in_act_r  <= in_action;
      in_byte_r <= in_data_byte;
    end
    // hold packet bytes
    if (store_we) begin
      store_r[pos_r] <= in_byte_r;
    end
    // event payload for the drain
    if (proc) begin
      press_r  <= lv;
      scroll_r <= wheel;
      mvx_r    <= pend_x_r;
      mvy_r    <= pend_y_r;
    end
  end

  // Load the output register from the selected slot
  always_ff @(posedge clk) begin
    if (drain) begin
      out_last_r   <= (mask_after == '0);
      out_btn_r    <= '0;
      out_scroll_r <= '0;
      out_mx_r     <= '0;
      out_my_r     <= '0;
      unique case (pick_idx) inside
        [3'd0:3'(NUM_BUTTONS-1)]: begin
          out_kind_r <= press_r[pick_idx] ? EV_PRESSED : EV_RELEASED;
          out_btn_r  <= pick_idx;
        end
        3'(SLOT_SCROLL): begin
          out_kind_r   <= EV_SCROLLED;
          out_scroll_r <= scroll_r;
        end
        3'(SLOT_MOVE): begin
          out_kind_r <= EV_MOVED;
          out_mx_r   <= mvx_r;
          out_my_r   <= mvy_r;
        end
        default: begin
          out_kind_r <= EV_MOVED;
        end
      endcase
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_kind    = out_kind_r;
  assign out_button_index  = out_btn_r;
  assign out_scroll_amount = out_scroll_r;
  assign out_move_x        = out_mx_r;
  assign out_move_y        = out_my_r;
  assign out_last_of_run   = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Pending events move to a free output register right away.
  a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (mask_r != '0 && out_adv) |=> out_vld_r)
    else $error("pending event not moved to output");

  // A result that is not the last of its run has more events behind it.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_last_r) |-> (mask_r != '0))
    else $error("run ended without last_of_run");

  // A flush clears both accumulators.
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_act_r) |=> (pend_x_r == '0 && pend_y_r == '0))
    else $error("accumulators not cleared by flush");

  // The input register is never overwritten while it still holds a transaction.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !proc) |=> (in_vld_r && $stable(in_byte_r) && $stable(in_act_r)))
    else $error("held transaction lost");

endmodule
`default_nettype wire
